### rtl/core/generational_handle_table_assert.svh
// Assertion macros used by the handle table checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table check failed");

// Consequent must hold in the cycle after the antecedent.
`define GHT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table check failed");

`endif

### rtl/core/ght_pkg.sv
// Package for the generational handle table: widths, beat payloads, codes,
// and the microcode program of the control sequencer. Depends on nothing.
package ght_pkg;

    localparam int unsigned CAPACITY = 256;
    localparam int unsigned IDX_W    = $clog2(CAPACITY);
    localparam int unsigned CNT_W    = IDX_W + 1;
    localparam int unsigned GEN_W    = 16;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned STEP_W   = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] key_index;
        logic [GEN_W-1:0] key_gen;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] out_index;
        logic [GEN_W-1:0] out_gen;
        logic [VAL_W-1:0] out_value;
        logic [CNT_W-1:0] live_count;
    } t_rsp;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [3:0] {
        A_IDLE,
        A_INS_CHECK,
        A_NOP,
        A_INS_REUSE,
        A_INS_FRESH,
        A_KEY_READ,
        A_KEY_CHECK,
        A_LK_READ,
        A_LK_TAKE,
        A_ER_READ_LAST,
        A_ER_MOVE,
        A_ER_FREE,
        A_CLEAR,
        A_RESPOND
    } t_act;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_FAIL,
        C_FRESH,
        C_OPCODE
    } t_cond;

    typedef enum logic [1:0] {
        H_NONE,
        H_INPUT,
        H_OUTPUT
    } t_hold;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_hold hold;
        t_step target;
    } t_uword;

    // Conditions the datapath reports back to the sequencer.
    typedef struct packed {
        logic [1:0] op;
        logic       accept;
        logic       out_busy;
        logic       fail;
        logic       fresh;
    } t_seq_in;

    localparam t_step S_IDLE        = 4'd0;
    localparam t_step S_INSERT      = 4'd1;
    localparam t_step S_INS_REUSE   = 4'd3;
    localparam t_step S_INS_FRESH   = 4'd4;
    localparam t_step S_LOOKUP      = 4'd5;
    localparam t_step S_ERASE       = 4'd9;
    localparam t_step S_CLEAR       = 4'd14;
    localparam t_step S_RESPOND     = 4'd15;

    // Entry point of each operation's routine.
    function automatic t_step op_vector(input logic [1:0] op);
        t_step s;
        unique case (op)
            OP_INSERT: s = S_INSERT;
            OP_LOOKUP: s = S_LOOKUP;
            OP_ERASE:  s = S_ERASE;
            OP_CLEAR:  s = S_CLEAR;
            default:   s = S_IDLE;
        endcase
        return s;
    endfunction

    // The control store: one word per step.
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            4'd0:    w = '{act: A_IDLE,         cond: C_OPCODE, hold: H_INPUT,  target: S_IDLE};
            4'd1:    w = '{act: A_INS_CHECK,    cond: C_FAIL,   hold: H_NONE,   target: S_RESPOND};
            4'd2:    w = '{act: A_NOP,          cond: C_FRESH,  hold: H_NONE,   target: S_INS_FRESH};
            4'd3:    w = '{act: A_INS_REUSE,    cond: C_JUMP,   hold: H_NONE,   target: S_RESPOND};
            4'd4:    w = '{act: A_INS_FRESH,    cond: C_JUMP,   hold: H_NONE,   target: S_RESPOND};
            4'd5:    w = '{act: A_KEY_READ,     cond: C_NEXT,   hold: H_NONE,   target: S_IDLE};
            4'd6:    w = '{act: A_KEY_CHECK,    cond: C_FAIL,   hold: H_NONE,   target: S_RESPOND};
            4'd7:    w = '{act: A_LK_READ,      cond: C_NEXT,   hold: H_NONE,   target: S_IDLE};
            4'd8:    w = '{act: A_LK_TAKE,      cond: C_JUMP,   hold: H_NONE,   target: S_RESPOND};
            4'd9:    w = '{act: A_KEY_READ,     cond: C_NEXT,   hold: H_NONE,   target: S_IDLE};
            4'd10:   w = '{act: A_KEY_CHECK,    cond: C_FAIL,   hold: H_NONE,   target: S_RESPOND};
            4'd11:   w = '{act: A_ER_READ_LAST, cond: C_NEXT,   hold: H_NONE,   target: S_IDLE};
            4'd12:   w = '{act: A_ER_MOVE,      cond: C_NEXT,   hold: H_NONE,   target: S_IDLE};
            4'd13:   w = '{act: A_ER_FREE,      cond: C_JUMP,   hold: H_NONE,   target: S_RESPOND};
            4'd14:   w = '{act: A_CLEAR,        cond: C_NEXT,   hold: H_NONE,   target: S_IDLE};
            4'd15:   w = '{act: A_RESPOND,      cond: C_JUMP,   hold: H_OUTPUT, target: S_IDLE};
            default: w = '{act: A_NOP,          cond: C_JUMP,   hold: H_NONE,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/ght_ifs.sv
// Valid/ready channel interfaces for the handle table request and response.
// Depends on ght_pkg for the payload types.
interface ght_req_if;
    logic         valid;
    logic         ready;
    ght_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ght_rsp_if;
    logic         valid;
    logic         ready;
    ght_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/ght_seq.sv
// Microcode sequencer of the handle table: step counter, control store and
// branch logic. Depends on ght_pkg for the control word and the program.
module ght_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ght_pkg::t_seq_in i_cond,
    output ght_pkg::t_uword  o_word
);
    import ght_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword s_word;
    logic   s_stall;

    assign s_word = ucode(r_step);
    assign o_word = s_word;

    always_comb begin
        s_stall = ((s_word.hold == H_INPUT) && !i_cond.accept) ||
                  ((s_word.hold == H_OUTPUT) && i_cond.out_busy);
        n_step  = t_step'(r_step + 1'b1);
        unique case (s_word.cond)
            C_NEXT:   n_step = t_step'(r_step + 1'b1);
            C_JUMP:   n_step = s_word.target;
            C_FAIL:   if (i_cond.fail) n_step = s_word.target;
            C_FRESH:  if (i_cond.fresh) n_step = s_word.target;
            C_OPCODE: n_step = op_vector(i_cond.op);
            default:  n_step = S_IDLE;
        endcase
        if (s_stall) begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### rtl/core/generational_handle_table.sv
// Generational handle table: slot store, dense value store and free list,
// driven by the ght_seq microcode sequencer. Depends on ght_pkg and ght_ifs.
//
// Usage: requests arrive on i_req (operation, key_index, key_gen, value) and
// one response per request leaves on o_rsp (status, out_index, out_gen,
// out_value, live_count). A beat moves when valid and ready are both high.
// The block works on one request at a time; i_req.ready is high only while
// the sequencer waits at its idle step.
// Each request runs as a microcode routine from the idle step through the
// respond step, and the next request is accepted only once the sequencer is
// back at its idle step. Erase is the longest routine: it chains a slot
// read, a read of the last dense entry, the move write and the free-list
// write, each memory having one read and one write port.
// Reset empties the table at once; no clearing pass is needed, since stale
// slot and dense entries are only used after they were written again.
// When the receiver stalls, the response is held in the output register;
// the next request is still accepted and runs until its own response is
// ready, then waits.
module generational_handle_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ght_req_if.sink        i_req,
    ght_rsp_if.source      o_rsp
);
    import ght_pkg::*;

    t_uword  s_word;
    t_seq_in s_cond;

    logic s_accept;
    logic s_out_busy;
    logic s_fresh;
    logic s_full;
    logic s_key_ok;
    logic s_fail;
    logic s_move;

    logic [IDX_W-1:0] s_slot;
    logic [CNT_W-1:0] s_last;

    // Table state.
    logic [CNT_W-1:0]    r_created;
    logic [CNT_W-1:0]    r_free_head;
    logic [CNT_W-1:0]    r_count;
    logic [CAPACITY-1:0] r_occ;

    // Latched request and working registers.
    logic [IDX_W-1:0] r_kidx;
    logic [GEN_W-1:0] r_kgen;
    logic [VAL_W-1:0] r_val;
    logic [CNT_W-1:0] r_pos;

    logic [1:0]       r_status;
    logic [IDX_W-1:0] r_res_index;
    logic [GEN_W-1:0] r_res_gen;
    logic [VAL_W-1:0] r_res_value;

    logic r_out_valid;
    t_rsp r_out;

    // Memories and their registered read data.
    logic [CNT_W-1:0] m_link  [CAPACITY];
    logic [GEN_W-1:0] m_gen   [CAPACITY];
    logic [VAL_W-1:0] m_value [CAPACITY];
    logic [IDX_W-1:0] m_owner [CAPACITY];

    logic [CNT_W-1:0] r_link_q;
    logic [GEN_W-1:0] r_gen_q;
    logic [VAL_W-1:0] r_val_q;
    logic [IDX_W-1:0] r_owner_q;

    // Memory port controls.
    logic             s_slot_re;
    logic [IDX_W-1:0] s_slot_raddr;
    logic             s_link_we;
    logic [IDX_W-1:0] s_link_waddr;
    logic [CNT_W-1:0] s_link_wdata;
    logic             s_gen_we;
    logic [IDX_W-1:0] s_gen_waddr;
    logic [GEN_W-1:0] s_gen_wdata;
    logic             s_dense_re;
    logic [IDX_W-1:0] s_dense_raddr;
    logic             s_dense_we;
    logic [IDX_W-1:0] s_dense_waddr;
    logic [VAL_W-1:0] s_val_wdata;
    logic [IDX_W-1:0] s_owner_wdata;

    ght_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (s_cond),
        .o_word  (s_word)
    );

    assign i_req.ready = (s_word.hold == H_INPUT);
    assign s_accept    = i_req.valid && i_req.ready;
    assign s_out_busy  = r_out_valid && !o_rsp.ready;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    assign s_slot  = r_free_head[IDX_W-1:0];
    assign s_last  = CNT_W'(r_count - 1'b1);
    assign s_fresh = (r_free_head == r_created);
    assign s_full  = (r_count >= CNT_W'(CAPACITY)) ||
                     (r_free_head >= CNT_W'(CAPACITY)) ||
                     (s_fresh && (r_created >= CNT_W'(CAPACITY)));
    assign s_key_ok = ({1'b0, r_kidx} < r_created) && r_occ[r_kidx] &&
                      (r_gen_q == r_kgen) && (r_count != '0);
    // The hole is filled only when the erased value is not the last one.
    assign s_move = (r_pos < CNT_W'(CAPACITY)) && (r_pos != s_last);

    always_comb begin
        s_fail = 1'b0;
        if (s_word.act == A_INS_CHECK) begin
            s_fail = s_full;
        end else if (s_word.act == A_KEY_CHECK) begin
            s_fail = !s_key_ok;
        end
    end

    assign s_cond = '{op:       i_req.payload.operation,
                      accept:   s_accept,
                      out_busy: s_out_busy,
                      fail:     s_fail,
                      fresh:    s_fresh};

    always_comb begin
        s_slot_re     = 1'b0;
        s_slot_raddr  = r_kidx;
        s_link_we     = 1'b0;
        s_link_waddr  = s_slot;
        s_link_wdata  = r_count;
        s_gen_we      = 1'b0;
        s_gen_waddr   = s_slot;
        s_gen_wdata   = '0;
        s_dense_re    = 1'b0;
        s_dense_raddr = r_pos[IDX_W-1:0];
        s_dense_we    = 1'b0;
        s_dense_waddr = r_count[IDX_W-1:0];
        s_val_wdata   = r_val;
        s_owner_wdata = s_slot;
        unique case (s_word.act)
            A_INS_CHECK: begin
                s_slot_re    = 1'b1;
                s_slot_raddr = s_slot;
            end
            A_INS_REUSE: begin
                s_dense_we = 1'b1;
                s_link_we  = 1'b1;
            end
            A_INS_FRESH: begin
                s_dense_we = 1'b1;
                s_link_we  = 1'b1;
                s_gen_we   = 1'b1;
            end
            A_KEY_READ: begin
                s_slot_re = 1'b1;
            end
            A_LK_READ: begin
                s_dense_re = 1'b1;
            end
            A_ER_READ_LAST: begin
                s_dense_re    = 1'b1;
                s_dense_raddr = s_last[IDX_W-1:0];
            end
            A_ER_MOVE: begin
                s_dense_we    = s_move;
                s_dense_waddr = r_pos[IDX_W-1:0];
                s_val_wdata   = r_val_q;
                s_owner_wdata = r_owner_q;
                s_link_we     = s_move;
                s_link_waddr  = r_owner_q;
                s_link_wdata  = r_pos;
            end
            A_ER_FREE: begin
                s_link_we    = 1'b1;
                s_link_waddr = r_kidx;
                s_link_wdata = r_free_head;
                s_gen_we     = 1'b1;
                s_gen_waddr  = r_kidx;
                s_gen_wdata  = GEN_W'(r_gen_q + 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_link_we) begin
            m_link[s_link_waddr] <= s_link_wdata;
        end
        if (s_slot_re) begin
            r_link_q <= m_link[s_slot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_gen_we) begin
            m_gen[s_gen_waddr] <= s_gen_wdata;
        end
        if (s_slot_re) begin
            r_gen_q <= m_gen[s_slot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_dense_we) begin
            m_value[s_dense_waddr] <= s_val_wdata;
        end
        if (s_dense_re) begin
            r_val_q <= m_value[s_dense_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_dense_we) begin
            m_owner[s_dense_waddr] <= s_owner_wdata;
        end
        if (s_dense_re) begin
            r_owner_q <= m_owner[s_dense_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_created   <= '0;
            r_free_head <= '0;
            r_count     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (s_word.act)
                A_INS_REUSE: begin
                    r_free_head   <= r_link_q;
                    r_occ[s_slot] <= 1'b1;
                    r_count       <= CNT_W'(r_count + 1'b1);
                end
                A_INS_FRESH: begin
                    r_free_head   <= CNT_W'(r_created + 1'b1);
                    r_created     <= CNT_W'(r_created + 1'b1);
                    r_occ[s_slot] <= 1'b1;
                    r_count       <= CNT_W'(r_count + 1'b1);
                end
                A_ER_FREE: begin
                    r_free_head   <= {1'b0, r_kidx};
                    r_occ[r_kidx] <= 1'b0;
                    r_count       <= s_last;
                end
                A_CLEAR: begin
                    r_created   <= '0;
                    r_free_head <= '0;
                    r_count     <= '0;
                    r_occ       <= '0;
                end
                default: begin
                end
            endcase
            if ((s_word.act == A_RESPOND) && !s_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kidx      <= i_req.payload.key_index;
            r_kgen      <= i_req.payload.key_gen;
            r_val       <= i_req.payload.value;
            r_status    <= ST_OK;
            r_res_index <= '0;
            r_res_gen   <= '0;
            r_res_value <= '0;
        end
        case (s_word.act)
            A_INS_CHECK: begin
                if (s_full) begin
                    r_status <= ST_FULL;
                end
            end
            A_INS_REUSE: begin
                r_res_index <= s_slot;
                r_res_gen   <= r_gen_q;
            end
            A_INS_FRESH: begin
                r_res_index <= s_slot;
                r_res_gen   <= '0;
            end
            A_KEY_CHECK: begin
                if (!s_key_ok) begin
                    r_status <= ST_INVALID;
                end
                r_pos <= r_link_q;
            end
            A_LK_TAKE: begin
                r_res_value <= (r_pos < CNT_W'(CAPACITY)) ? r_val_q : '0;
            end
            A_RESPOND: begin
                if (!s_out_busy) begin
                    r_out <= '{status:     r_status,
                               out_index:  r_res_index,
                               out_gen:    r_res_gen,
                               out_value:  r_res_value,
                               live_count: r_count};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/core/ght_checker.sv
// Port-level checks of the handle table, attached by a bind statement.
// Depends on ght_pkg and generational_handle_table_assert.svh.
`include "generational_handle_table_assert.svh"

module ght_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input ght_pkg::t_rsp i_rsp_payload
);
    import ght_pkg::*;

    logic s_status_known;
    logic s_count_known;
    logic s_rsp_failed;
    logic s_no_result;
    logic s_req_beat;
    logic s_rsp_wait;

    assign s_status_known = (i_rsp_payload.status == ST_OK) ||
                            (i_rsp_payload.status == ST_INVALID) ||
                            (i_rsp_payload.status == ST_FULL);
    assign s_count_known  = (i_rsp_payload.live_count <= CNT_W'(CAPACITY));
    assign s_rsp_failed   = i_rsp_valid && (i_rsp_payload.status != ST_OK);
    assign s_no_result    = (i_rsp_payload.out_index == '0) &&
                            (i_rsp_payload.out_gen == '0) &&
                            (i_rsp_payload.out_value == '0);
    assign s_req_beat     = i_req_valid && i_req_ready;
    assign s_rsp_wait     = i_rsp_valid && !i_rsp_ready;

    `GHT_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, i_rsp_valid, s_status_known)
    `GHT_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, i_rsp_valid, s_count_known)
    // A refused request reports no key and no value.
    `GHT_ASSERT_IMPL(a_fail_clean, i_clk, i_rst_n, s_rsp_failed, s_no_result)
    // Requests are handled one at a time.
    `GHT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_req_beat, !i_req_ready)
    `GHT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, s_rsp_wait, i_rsp_valid && $stable(i_rsp_payload))

endmodule

bind generational_handle_table ght_checker u_ght_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);

### dv/ght_reply_checker.sv
// Reply checker for the generational handle table: watches both channels,
// predicts every reply and compares it field by field with what the block sends.
// Depends on ght_pkg and the channel interfaces in ght_ifs.
module ght_reply_checker
    import ght_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    ght_req_if    i_req,
    ght_rsp_if    i_rsp,
    output int    o_error_count,
    output int    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Own copy of the table: packed values, their owning slots, and per slot
    // either the dense position (live) or the next free slot (free).
    logic [VAL_W-1:0] dense_val  [CAPACITY];
    int unsigned      dense_slot [CAPACITY];
    int unsigned      slot_link  [CAPACITY];
    logic [GEN_W-1:0] slot_gen   [CAPACITY];
    bit               slot_live  [CAPACITY];
    int unsigned      made_count;
    int unsigned      free_head;
    int unsigned      live_count;

    t_rsp expected_replies[$];
    t_rsp oldest;
    int   mismatches = 0;

    function automatic void forget_slots();
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        made_count = 0;
        free_head  = 0;
        live_count = 0;
    endfunction

    function automatic bit key_valid(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
        return (idx < made_count) && slot_live[idx] && (slot_gen[idx] == gen);
    endfunction

    // Applies one request to the table copy and returns the reply it causes.
    function automatic t_rsp predict_reply(t_req r);
        t_rsp        rsp;
        int unsigned s;
        int unsigned pos;
        int unsigned last;
        int unsigned owner;
        rsp = '0;
        case (r.operation)
            OP_INSERT: begin
                s = free_head;
                if (live_count >= CAPACITY || s >= CAPACITY ||
                    (s == made_count && made_count >= CAPACITY)) begin
                    rsp.status = ST_FULL;
                end else begin
                    pos = live_count;
                    if (s == made_count) begin
                        slot_gen[s]  = '0;
                        slot_link[s] = s + 1;
                        made_count++;
                    end
                    free_head       = slot_link[s];
                    dense_val[pos]  = r.value;
                    dense_slot[pos] = s;
                    slot_link[s]    = pos;
                    slot_live[s]    = 1'b1;
                    live_count++;
                    rsp.out_index = IDX_W'(s);
                    rsp.out_gen   = slot_gen[s];
                end
            end
            OP_LOOKUP: begin
                if (!key_valid(r.key_index, r.key_gen)) begin
                    rsp.status = ST_INVALID;
                end else begin
                    rsp.out_value = dense_val[slot_link[r.key_index]];
                end
            end
            OP_ERASE: begin
                if (!key_valid(r.key_index, r.key_gen) || live_count == 0) begin
                    rsp.status = ST_INVALID;
                end else begin
                    s    = r.key_index;
                    pos  = slot_link[s];
                    last = live_count - 1;
                    // The last packed value fills the hole and its slot is repointed.
                    if (pos != last) begin
                        owner            = dense_slot[last];
                        dense_val[pos]   = dense_val[last];
                        dense_slot[pos]  = owner;
                        slot_link[owner] = pos;
                    end
                    live_count   = last;
                    slot_link[s] = free_head;
                    free_head    = s;
                    slot_gen[s]  = slot_gen[s] + 1'b1;
                    slot_live[s] = 1'b0;
                end
            end
            OP_CLEAR: begin
                forget_slots();
            end
        endcase
        rsp.live_count = CNT_W'(live_count);
        return rsp;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            forget_slots();
            expected_replies.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    $error("reply beat arrived with no request waiting for it");
                end else begin
                    oldest = expected_replies.pop_front();
                    compare_field("status", oldest.status, i_rsp.payload.status);
                    compare_field("out_index", oldest.out_index, i_rsp.payload.out_index);
                    compare_field("out_gen", oldest.out_gen, i_rsp.payload.out_gen);
                    compare_field("out_value", oldest.out_value, i_rsp.payload.out_value);
                    compare_field("live_count", oldest.live_count,
                                  i_rsp.payload.live_count);
                end
            end
            if (i_req.valid && i_req.ready)
                expected_replies.push_back(predict_reply(i_req.payload));
        end
        o_error_count <= mismatches;
        o_outstanding <= expected_replies.size();
    end

endmodule

### dv/tb_generational_handle_table.sv
// Top of the handle table testbench: clock, reset, request stimulus and reply
// back-pressure, with the verdict taken from ght_reply_checker.
// Depends on ght_pkg, ght_ifs, ght_reply_checker and the block itself.
module tb_generational_handle_table;
    timeunit 1ns;
    timeprecision 1ps;

    import ght_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int GEN_ROUNDS   = 32;
    localparam int DRAIN_FLOOR  = 4;
    localparam int FULL_REPLIES = 6;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] gen;
    } t_key;

    logic clk;
    logic rst_n;
    int   error_count;
    int   outstanding;
    bit   fast_mode;

    ght_req_if req_if();
    ght_rsp_if rsp_if();

    generational_handle_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    ght_reply_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    // Bookkeeping that steers the stimulus: keys handed out, slots ever made,
    // and the latest fill level reported by the block.
    t_key        live_keys[$];
    t_req        in_flight[$];
    t_req        sent;
    t_rsp        got;
    int unsigned slots_written = 0;
    int unsigned seen_live     = 0;
    int          full_replies  = 0;
    int          burst_left    = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("generational_handle_table regression: fail");
        $finish;
    end

    // Sampled on the falling edge so it never races the stimulus process.
    always @(negedge clk) begin : track_keys
        if (rsp_if.valid && rsp_if.ready && in_flight.size() > 0) begin
            sent      = in_flight.pop_front();
            got       = rsp_if.payload;
            seen_live = got.live_count;
            if (got.status == ST_FULL)
                full_replies++;
            if (got.status == ST_OK) begin
                case (sent.operation)
                    OP_INSERT: begin
                        live_keys.push_back({got.out_index, got.out_gen});
                        if (int'(got.out_index) >= slots_written)
                            slots_written = int'(got.out_index) + 1;
                    end
                    OP_ERASE: begin
                        for (int i = 0; i < live_keys.size(); i++) begin
                            if (live_keys[i] == {sent.key_index, sent.key_gen}) begin
                                live_keys.delete(i);
                                break;
                            end
                        end
                    end
                    OP_CLEAR: live_keys.delete();
                    default: ;
                endcase
            end
        end
        if (req_if.valid && req_if.ready)
            in_flight.push_back(req_if.payload);
    end

    // Reply side: the ready pattern switches between random stall styles, with one long hold-off
    // that lets the block fill its output register and refuse new beats.
    initial begin : reply_backpressure
        int cyc;
        int style;
        bit held;
        rsp_if.ready <= 1'b0;
        cyc   = 0;
        style = 0;
        held  = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (cyc % 64 == 0)
                style = $urandom_range(3);
            if (!fast_mode && !held && cyc >= 3000) begin
                rsp_if.ready <= 1'b0;
                repeat (500) @(posedge clk);
                held = 1'b1;
            end else begin
                if (fast_mode)
                    rsp_if.ready <= 1'b1;
                else begin
                    case (style)
                        0:       rsp_if.ready <= 1'b1;
                        1:       rsp_if.ready <= 1'($urandom_range(1));
                        2:       rsp_if.ready <= ($urandom_range(4) == 0);
                        default: rsp_if.ready <= ((cyc % 9) >= 3);
                    endcase
                end
                @(posedge clk);
            end
            cyc++;
        end
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Offers one request beat and returns at the edge that takes it.
    task automatic push_request(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [GEN_W-1:0] gen,
                                input logic [VAL_W-1:0] val);
        t_req beat;
        int   gap;
        beat.operation = op;
        beat.key_index = idx;
        beat.key_gen   = gen;
        beat.value     = val;
        if (!fast_mode && burst_left == 0) begin
            req_if.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 12);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= beat;
        do @(posedge clk); while (!req_if.ready);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Lookup or erase with a key that is mostly live, sometimes one generation
    // off (a freed or reused slot), sometimes corrupted or made up.
    task automatic push_keyed(input logic [1:0] op);
        t_key k;
        int   pick;
        if (slots_written == 0) begin
            push_request(OP_INSERT, '0, '0, rand_value());
        end else begin
            pick = $urandom_range(9);
            if (pick < 9 && live_keys.size() > 0) begin
                k = live_keys[$urandom_range(live_keys.size() - 1)];
                if (pick == 7)
                    k.gen = k.gen ^ (GEN_W'(1) << $urandom_range(GEN_W - 1));
                else if (pick == 8)
                    k.gen = $urandom_range(1) ? k.gen + 1'b1 : k.gen - 1'b1;
            end else begin
                k.index = IDX_W'($urandom_range(slots_written - 1));
                k.gen   = GEN_W'($urandom);
            end
            push_request(op, k.index, k.gen, VAL_W'($urandom));
        end
    endtask

    initial begin : stimulus
        bit draining;
        int roll;
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        fast_mode      <= 1'b0;
        draining = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: basic flow, value extremes, bad keys, hole filling on erase,
        // free-slot rejection, erase on an empty table, clear and fresh generations.
        push_request(OP_CLEAR,  8'd0, 16'd0, '0);
        push_request(OP_INSERT, 8'd0, 16'd0, '0);
        push_request(OP_INSERT, 8'd0, 16'd0, '1);
        push_request(OP_INSERT, 8'd0, 16'd0, 32'hA5A5_5A5A);
        push_request(OP_LOOKUP, 8'd0, 16'd0, '0);
        push_request(OP_LOOKUP, 8'd1, 16'd0, '0);
        push_request(OP_LOOKUP, 8'd1, 16'd1, '0);
        push_request(OP_ERASE,  8'd0, 16'd0, '0);
        push_request(OP_LOOKUP, 8'd0, 16'd1, '0);
        push_request(OP_LOOKUP, 8'd2, 16'd0, '0);
        push_request(OP_ERASE,  8'd0, 16'd1, '0);
        push_request(OP_INSERT, 8'd0, 16'd0, 32'h0000_1234);
        push_request(OP_LOOKUP, 8'd0, 16'd1, '0);
        push_request(OP_ERASE,  8'd2, 16'd0, '0);
        push_request(OP_ERASE,  8'd1, 16'd0, '0);
        push_request(OP_ERASE,  8'd0, 16'd1, '0);
        push_request(OP_ERASE,  8'd1, 16'd0, '0);
        push_request(OP_LOOKUP, 8'd1, '1, '0);
        push_request(OP_CLEAR,  8'd0, 16'd0, '0);
        push_request(OP_INSERT, 8'd0, 16'd0, 32'h8000_0001);
        push_request(OP_LOOKUP, 8'd0, 16'd0, '0);
        push_request(OP_LOOKUP, 8'd2, 16'd2, '0);

        // Random: alternate between filling to the brim and draining down.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (!draining && full_replies >= FULL_REPLIES) begin
                draining = 1'b1;
            end else if (draining && seen_live <= DRAIN_FLOOR) begin
                draining     = 1'b0;
                full_replies = 0;
            end
            roll = $urandom_range(99);
            if (roll < (draining ? 10 : 70))
                push_request(OP_INSERT, IDX_W'($urandom), GEN_W'($urandom), rand_value());
            else if (roll < (draining ? 30 : 90))
                push_keyed(OP_LOOKUP);
            else if (draining && roll == 99 && $urandom_range(3) == 0)
                push_request(OP_CLEAR, IDX_W'($urandom), GEN_W'($urandom), rand_value());
            else
                push_keyed(OP_ERASE);
        end

        // Generation steps: after a clear slot 0 heads the free list, so
        // alternating erase and insert bumps its generation once per round.
        fast_mode <= 1'b1;
        push_request(OP_CLEAR,  8'd0, 16'd0, '0);
        push_request(OP_INSERT, 8'd0, 16'd0, rand_value());
        for (int k = 0; k < GEN_ROUNDS; k++) begin
            push_request(OP_ERASE,  8'd0, GEN_W'(k), '0);
            push_request(OP_INSERT, 8'd0, 16'd0, rand_value());
        end
        push_request(OP_LOOKUP, 8'd0, GEN_W'(GEN_ROUNDS), '0);
        push_request(OP_LOOKUP, 8'd0, GEN_W'(GEN_ROUNDS - 1), '0);

        req_if.valid <= 1'b0;
        for (int w = 0; w < 50000 && outstanding != 0; w++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("generational_handle_table regression: pass");
        else
            $display("generational_handle_table regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ght_pkg.sv
rtl/core/ght_ifs.sv
rtl/core/ght_seq.sv
rtl/core/generational_handle_table.sv
rtl/core/ght_checker.sv
dv/ght_reply_checker.sv
dv/tb_generational_handle_table.sv
